[hdl/stp_pkg.sv]
// Shared types, constants and exp table for the short-term plasticity block.
package stp_pkg;

    localparam int unsigned NumSynapsesDef = 256;
    localparam logic [16:0] OneQ16         = 17'd65536;
    localparam logic [31:0] RndQ32         = 32'h8000_0000;
    localparam logic [31:0] RndQ16         = 32'h0000_8000;
    localparam int unsigned ExpBits        = 20;

    localparam logic [1:0] REG_USE_INC  = 2'd0;
    localparam logic [1:0] REG_FAC_RATE = 2'd1;
    localparam logic [1:0] REG_REC_RATE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_X,
        ST_EXP,
        ST_EXPW,
        ST_FAC,
        ST_U1,
        ST_U2,
        ST_P1,
        ST_W,
        ST_OUT
    } t_state;

    // round(exp(-2^(b-16)) * 2^32)
    function automatic logic [31:0] exp_k(input logic [4:0] b);
        logic [31:0] k;
        case (b)
            5'd0:    k = 32'd4294901761;
            5'd1:    k = 32'd4294836226;
            5'd2:    k = 32'd4294705160;
            5'd3:    k = 32'd4294443040;
            5'd4:    k = 32'd4293918848;
            5'd5:    k = 32'd4292870656;
            5'd6:    k = 32'd4290775039;
            5'd7:    k = 32'd4286586875;
            5'd8:    k = 32'd4278222805;
            5'd9:    k = 32'd4261543595;
            5'd10:   k = 32'd4228380000;
            5'd11:   k = 32'd4162825044;
            5'd12:   k = 32'd4034748382;
            5'd13:   k = 32'd3790295335;
            5'd14:   k = 32'd3344923893;
            5'd15:   k = 32'd2605029347;
            5'd16:   k = 32'd1580030169;
            5'd17:   k = 32'd581260615;
            5'd18:   k = 32'd78665070;
            5'd19:   k = 32'd1440801;
            default: k = 32'd0;
        endcase
        return k;
    endfunction

endpackage

[hdl/stp_mac.sv]
// Shared registered multiply-add unit.
module stp_mac
    import stp_pkg::*;
(
    input  logic        i_clk,
    input  logic [32:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [64:0] o_prod
);

    logic [64:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= ({32'd0, i_a} * {33'd0, i_b}) + {33'd0, i_c};
    end

    assign o_prod = r_prod;

endmodule

[hdl/stp_store.sv]
// Per-synapse use and availability memory with reset-valid bits.
module stp_store
    import stp_pkg::*;
#(
    parameter int unsigned NUM_SYNAPSES = NumSynapsesDef,
    localparam int unsigned AW = (NUM_SYNAPSES > 1) ? $clog2(NUM_SYNAPSES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [16:0]   i_wuse,
    input  logic [16:0]   i_wavail,
    input  logic [AW-1:0] i_raddr,
    output logic [16:0]   o_ruse,
    output logic [16:0]   o_ravail
);

    logic [33:0]             r_mem [NUM_SYNAPSES];
    logic [NUM_SYNAPSES-1:0] r_valid;
    logic [33:0]             r_rdata;
    logic                    r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wavail, i_wuse};
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= r_valid[i_raddr];
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_ruse   = r_rvalid ? r_rdata[16:0]  : 17'd0;
    assign o_ravail = r_rvalid ? r_rdata[33:17] : OneQ16;

endmodule

[hdl/short_term_synaptic_plasticity.sv]
// Top level: short-term synaptic plasticity update engine.
//
// Slave stream carries one presynaptic spike per item: synapse index and the
// ticks since that synapse last released. Master stream returns one item per
// spike: the synapse id and its new weight use*avail (Q1.16).
// Config port writes use_increment, facilitation_rate and recovery_rate.
//
// All multiplications run through one registered multiplier under a sequencer.
// Each exponential costs one multiply for x, then scans the 20 low bits of x;
// a set bit multiplies the accumulator by its table constant, a clear bit is skipped.
// An out-of-range synapse presents weight 0 in the cycle after accept.
// The slave side is not ready while an item is in work or its result waits.
// A stalled receiver holds the result; nothing is dropped.
// Reset (synchronous, active low) returns registers to defaults and marks all
// synapses as use 0, avail 1.0 through per-entry valid bits; no clearing pass.
module short_term_synaptic_plasticity
    import stp_pkg::*;
#(
    parameter int unsigned NUM_SYNAPSES = NumSynapsesDef,
    localparam int unsigned AW = (NUM_SYNAPSES > 1) ? $clog2(NUM_SYNAPSES) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] synapse_index, [31:8] elapsed_ticks
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] synapse_id, [24:8] weight, zero pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [16:0] r_inc;
    logic [23:0] r_fac, r_rec;
    logic [7:0]  r_id;
    logic [23:0] r_el;
    logic [16:0] r_u, n_u, r_p, n_p, r_w, n_w;
    logic [32:0] r_acc, n_acc;
    logic [19:0] r_x, n_x;
    logic        r_zero, n_zero;
    logic [4:0]  r_bit, n_bit;
    logic        r_sel, n_sel;

    logic [32:0] mul_a;
    logic [31:0] mul_b, mul_c;
    logic [64:0] prod;
    logic [16:0] ruse, ravail, dfac, inc_c, pq;
    logic        we, in_range, acc_in;
    logic [AW-1:0] addr_in, addr_id;

    assign acc_in   = s_axis_tvalid && s_axis_tready;
    assign in_range = {9'd0, s_axis_tdata[7:0]} < 17'(NUM_SYNAPSES);
    assign addr_in  = AW'({16'd0, s_axis_tdata[7:0]});
    assign addr_id  = AW'({16'd0, r_id});
    assign inc_c    = (r_inc > OneQ16) ? OneQ16 : r_inc;
    assign dfac     = r_zero ? 17'd0 : 17'(({1'b0, r_acc} + 34'd32768) >> 16);
    assign pq       = prod[32:16];

    stp_mac u_mac (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .i_c   (mul_c),
        .o_prod(prod)
    );

    stp_store #(.NUM_SYNAPSES(NUM_SYNAPSES)) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we),
        .i_waddr (addr_id),
        .i_wuse  (r_u),
        .i_wavail(n_p),
        .i_raddr (addr_in),
        .o_ruse  (ruse),
        .o_ravail(ravail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_inc   <= OneQ16;
            r_fac   <= 24'd65536;
            r_rec   <= 24'd65536;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_USE_INC:  r_inc <= i_cfg_data[16:0];
                    REG_FAC_RATE: r_fac <= i_cfg_data;
                    REG_REC_RATE: r_rec <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_id <= s_axis_tdata[7:0];
            r_el <= s_axis_tdata[31:8];
        end
        r_u    <= n_u;
        r_p    <= n_p;
        r_w    <= n_w;
        r_acc  <= n_acc;
        r_x    <= n_x;
        r_zero <= n_zero;
        r_bit  <= n_bit;
        r_sel  <= n_sel;
    end

    always_comb begin
        n_state = r_state;
        n_u = r_u; n_p = r_p; n_w = r_w; n_acc = r_acc;
        n_x = r_x; n_zero = r_zero; n_bit = r_bit; n_sel = r_sel;
        mul_a = {9'd0, r_el};
        mul_b = {8'd0, r_fac};
        mul_c = 32'd0;
        we = 1'b0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_w = 17'd0;
                    n_state = in_range ? ST_READ : ST_OUT;
                end
            end
            ST_READ: begin
                n_u = (ruse > OneQ16) ? OneQ16 : ruse;
                n_p = (ravail > OneQ16) ? OneQ16 : ravail;
                n_sel = 1'b0;
                n_state = ST_X;
            end
            ST_X: begin
                n_x = prod[19:0];
                n_zero = |prod[47:20];
                n_acc = 33'h1_0000_0000;
                n_bit = 5'd0;
                n_state = ST_EXP;
            end
            ST_EXP: begin
                mul_a = r_acc;
                mul_b = exp_k(r_bit);
                mul_c = RndQ32;
                if (r_x[r_bit]) begin
                    n_state = ST_EXPW;
                end else begin
                    n_bit = r_bit + 5'd1;
                    if (r_bit == 5'(ExpBits - 1)) n_state = ST_FAC;
                end
            end
            ST_EXPW: begin
                n_acc = prod[64:32];
                n_bit = r_bit + 5'd1;
                n_state = (r_bit == 5'(ExpBits - 1)) ? ST_FAC : ST_EXP;
            end
            ST_FAC: begin
                mul_b = {15'd0, dfac};
                mul_c = RndQ16;
                if (!r_sel) begin
                    mul_a = {16'd0, r_u};
                    n_state = ST_U1;
                end else begin
                    mul_a = {16'd0, OneQ16 - r_p};
                    n_state = ST_P1;
                end
            end
            ST_U1: begin
                n_u = pq;
                mul_a = {16'd0, inc_c};
                mul_b = {15'd0, OneQ16 - pq};
                mul_c = RndQ16;
                n_state = ST_U2;
            end
            ST_U2: begin
                n_u = r_u + pq;
                mul_b = {8'd0, r_rec};
                n_sel = 1'b1;
                n_state = ST_X;
            end
            ST_P1: begin
                n_p = OneQ16 - pq;
                mul_a = {16'd0, r_u};
                mul_b = {15'd0, OneQ16 - pq};
                mul_c = RndQ16;
                n_state = ST_W;
            end
            ST_W: begin
                n_w = pq;
                n_p = r_p - pq;
                we = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign m_axis_tdata = {7'd0, r_w, r_id};

`ifndef SYNTHESIS
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_w <= OneQ16))
        else $error("weight above one");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("accept while result pending");
    a_avail_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_W) |-> (pq <= r_p))
        else $error("weight exceeds availability");
`endif

endmodule

[test/stp_checker.sv]
// Checker for the short-term plasticity block: predicts weights and compares stream results.
module stp_checker
    import stp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  id;
        logic [16:0] weight;
    } t_weight_item;

    localparam logic [63:0] ONE = 64'd65536;

    logic [16:0] use_mem [256];
    logic [16:0] avail_mem [256];
    logic [16:0] use_inc_reg;
    logic [23:0] fac_rate_reg;
    logic [23:0] rec_rate_reg;
    t_weight_item weight_q[$];
    int fails;

    localparam logic [31:0] KTAB [20] = '{
        32'd4294901761, 32'd4294836226, 32'd4294705160, 32'd4294443040,
        32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
    };

    function automatic logic [63:0] decay_q16(logic [23:0] ticks, logic [23:0] rate);
        logic [63:0] x;
        logic [63:0] acc;
        x = 64'(ticks) * 64'(rate);
        acc = 64'h1_0000_0000;
        if (x >= 64'(1 << 20)) return 64'd0;
        for (int b = 0; b < 20; b++)
            if (x[b]) acc = (acc * 64'(KTAB[b]) + 64'h8000_0000) >> 32;
        return (acc + 64'd32768) >> 16;
    endfunction

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        return (a * b + 64'd32768) >> 16;
    endfunction

    function automatic t_weight_item spike_weight(logic [7:0] idx, logic [23:0] ticks);
        t_weight_item r;
        logic [63:0] inc, u, p, w;
        r.id = idx;
        inc = (use_inc_reg > ONE) ? ONE : 64'(use_inc_reg);
        u = use_mem[idx];
        p = avail_mem[idx];
        if (u > ONE) u = ONE;
        if (p > ONE) p = ONE;
        u = qmul(u, decay_q16(ticks, fac_rate_reg));
        u = u + qmul(inc, ONE - u);
        p = ONE - qmul(ONE - p, decay_q16(ticks, rec_rate_reg));
        w = qmul(u, p);
        p = p - w;
        use_mem[idx] = u[16:0];
        avail_mem[idx] = p[16:0];
        r.weight = w[16:0];
        return r;
    endfunction

    assign o_fail_count = fails;

    always @(posedge i_clk) begin
        t_weight_item e, a;
        if (!i_rst_n) begin
            for (int i = 0; i < 256; i++) begin
                use_mem[i] = '0;
                avail_mem[i] = 17'd65536;
            end
            use_inc_reg = 17'd65536;
            fac_rate_reg = 24'd65536;
            rec_rate_reg = 24'd65536;
            weight_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_USE_INC:  use_inc_reg = i_cfg_data[16:0];
                    REG_FAC_RATE: fac_rate_reg = i_cfg_data;
                    REG_REC_RATE: rec_rate_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                a.id = m_axis_tdata[7:0];
                a.weight = m_axis_tdata[24:8];
                if (weight_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected item id=%0d w=%0d", a.id, a.weight);
                end else begin
                    e = weight_q.pop_front();
                    if (e != a || m_axis_tdata[31:25] != 0) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp id=%0d w=%0d, got id=%0d w=%0d pad=%0h",
                                     e.id, e.weight, a.id, a.weight, m_axis_tdata[31:25]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                weight_q.push_back(spike_weight(s_axis_tdata[7:0], s_axis_tdata[31:8]));
        end
        o_pending = weight_q.size();
    end
endmodule

[test/tb.sv]
// Testbench top: drives spikes and config writes, gives the verdict.
module tb;
    import stp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;   // [7:0] synapse_index, [31:8] elapsed_ticks
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;       // [7:0] synapse_id, [24:8] weight
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_addr = 0;
    logic [23:0] i_cfg_data = 0;
    int fail_count, pending;
    int idle_cycles = 0;
    bit quiet = 0;

    always #1 i_clk = ~i_clk;

    short_term_synaptic_plasticity dut (.*);
    stp_checker chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    // receiver stalls in bursts
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 16);
                m_axis_tready <= 0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("short_term_synaptic_plasticity regression: fail");
            $finish;
        end
    end

    task automatic send_spike(logic [7:0] idx, logic [23:0] ticks);
        if (!quiet && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {ticks, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [23:0] val);
        i_cfg_we <= 1;
        i_cfg_addr <= addr;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_ticks();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 3));
            1: return 24'($urandom_range(0, 40));
            2: return 24'($urandom_range(0, 1000));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_rate();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 4096));
            1: return 24'($urandom_range(0, 131072));
            2: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: defaults, extremes, long silence
        send_spike(8'd0, 24'd0);
        send_spike(8'd0, 24'd0);
        send_spike(8'd0, 24'd1);
        send_spike(8'd255, 24'hFFFFFF);
        send_spike(8'd255, 24'd16);
        send_spike(8'd1, 24'd15);
        drain();
        write_reg(REG_USE_INC, 24'd0);
        write_reg(REG_FAC_RATE, 24'd0);
        write_reg(REG_REC_RATE, 24'd0);
        write_reg(2'd3, 24'hFFFFFF);   // unmapped index
        send_spike(8'd2, 24'hFFFFFF);
        send_spike(8'd2, 24'd5);
        drain();
        write_reg(REG_USE_INC, 24'h01FFFF);   // oversized increment
        write_reg(REG_FAC_RATE, 24'hFFFFFF);
        write_reg(REG_REC_RATE, 24'd1);
        send_spike(8'd3, 24'd1);
        send_spike(8'd3, 24'd0);
        send_spike(8'd3, 24'h800000);
        drain();
        write_reg(REG_USE_INC, 24'd13107);
        write_reg(REG_FAC_RATE, 24'd6554);
        write_reg(REG_REC_RATE, 24'd3277);
        for (int i = 0; i < 8; i++) send_spike(8'd4, 24'd2);
        drain();
        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_USE_INC, ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 131071))
                                                             : 24'($urandom_range(0, 65536)));
            write_reg(REG_FAC_RATE, rand_rate());
            write_reg(REG_REC_RATE, rand_rate());
            if (ph == 11) quiet = 1;
            for (int k = 0; k < 77; k++) begin
                if ($urandom_range(0, 1))
                    send_spike(8'($urandom_range(0, 7)), rand_ticks());
                else
                    send_spike(8'($urandom), rand_ticks());
            end
            drain();
        end
        if (fail_count == 0)
            $display("short_term_synaptic_plasticity regression: pass");
        else
            $display("short_term_synaptic_plasticity regression: fail");
        $finish;
    end
endmodule
